>>> src/fsrm_pkg.sv
`timescale 1ns / 1ps
// fsrm_pkg: shared types and codes of the frame slot ring manager
// depends on nothing; used by every module of the block

package fsrm_pkg;

   // operation codes of the request word
   localparam logic [2:0] OP_PACKET     = 3'd0;
   localparam logic [2:0] OP_FRAME_DONE = 3'd1;
   localparam logic [2:0] OP_CONV_GET   = 3'd2;
   localparam logic [2:0] OP_CONV_PUT   = 3'd3;
   localparam logic [2:0] OP_USER_GET   = 3'd4;
   localparam logic [2:0] OP_USER_PUT   = 3'd5;
   localparam logic [2:0] OP_STATS      = 3'd6;

   // slot states
   localparam logic [2:0] SLOT_FREE       = 3'd0;
   localparam logic [2:0] SLOT_READY      = 3'd1;
   localparam logic [2:0] SLOT_CONVERTING = 3'd2;
   localparam logic [2:0] SLOT_CONVERTED  = 3'd3;
   localparam logic [2:0] SLOT_IN_USER    = 3'd4;

   // response status codes
   localparam logic [1:0] STAT_OK       = 2'd0;
   localparam logic [1:0] STAT_NO_SLOT  = 2'd1;
   localparam logic [1:0] STAT_MISMATCH = 2'd2;
   localparam logic [1:0] STAT_BAD_SLOT = 2'd3;

   // pipeline modes
   localparam logic [1:0] MODE_EXT_CONV   = 2'd0;
   localparam logic [1:0] MODE_INT_CONV   = 2'd1;
   localparam logic [1:0] MODE_PASS       = 2'd2;
   localparam logic [1:0] MODE_PER_PACKET = 2'd3;

   // register indexes of the csr port
   localparam logic CSR_SLOT_COUNT    = 1'b0;
   localparam logic CSR_PIPELINE_MODE = 1'b1;

   localparam logic [4:0] SLOT_COUNT_RESET = 5'd16;

   // command kinds handed from front to back
   localparam logic [3:0] CMD_NONE       = 4'd0;
   localparam logic [3:0] CMD_CLAIM      = 4'd1;
   localparam logic [3:0] CMD_MATCH      = 4'd2;
   localparam logic [3:0] CMD_DONE_FREE  = 4'd3;
   localparam logic [3:0] CMD_DONE_MATCH = 4'd4;
   localparam logic [3:0] CMD_CONV_GET   = 4'd5;
   localparam logic [3:0] CMD_CONV_PUT   = 4'd6;
   localparam logic [3:0] CMD_USER_GET   = 4'd7;
   localparam logic [3:0] CMD_USER_PUT   = 4'd8;
   localparam logic [3:0] CMD_STATS      = 4'd9;

   typedef struct packed {
      logic [3:0]  kind;
      logic [2:0]  want;        // state searched for or checked
      logic [2:0]  done_state;  // state a completed frame moves to
      logic        notify_app;
      logic        notify_converter;
      logic [31:0] timestamp;
      logic [3:0]  slot_index;
      logic        convert_failed;
   } cmd_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [3:0]  found_slot;
      logic        notify_app;
      logic        notify_converter;
      logic [31:0] busy_drops;
      logic [31:0] convert_fails;
   } rsp_type;

endpackage

>>> src/fsrm_req_if.sv
`timescale 1ns / 1ps
// fsrm_req_if: request channel of the frame slot ring manager
// depends on nothing

interface fsrm_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  op;
   logic [31:0] timestamp;
   logic        first_packet;
   logic [3:0]  slot_index;
   logic        convert_failed;

   modport source (output valid, op, timestamp, first_packet, slot_index, convert_failed,
                   input ready);
   modport sink (input valid, op, timestamp, first_packet, slot_index, convert_failed,
                 output ready);
endinterface

>>> src/fsrm_rsp_if.sv
`timescale 1ns / 1ps
// fsrm_rsp_if: response channel of the frame slot ring manager
// depends on nothing

interface fsrm_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [3:0]  found_slot;
   logic        notify_app;
   logic        notify_converter;
   logic [31:0] busy_drops;
   logic [31:0] convert_fails;

   modport source (output valid, status, found_slot, notify_app, notify_converter,
                   busy_drops, convert_fails, input ready);
   modport sink (input valid, status, found_slot, notify_app, notify_converter,
                 busy_drops, convert_fails, output ready);
endinterface

>>> src/fsrm_csr_if.sv
`timescale 1ns / 1ps
// fsrm_csr_if: configuration write channel of the frame slot ring manager
// depends on nothing

interface fsrm_csr_if;
   logic       valid;
   logic       ready;
   logic       index;
   logic [4:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

>>> src/fsrm_front.sv
`timescale 1ns / 1ps
// fsrm_front: takes request words, classifies them into commands, holds config
// depends on fsrm_pkg, fsrm_req_if and fsrm_csr_if

module fsrm_front (
   input  logic              clock,
   input  logic              reset,
   fsrm_req_if.sink          req_chan,
   fsrm_csr_if.sink          csr_chan,
   output fsrm_pkg::cmd_type cmd,
   output logic              cmd_valid,
   input  logic              cmd_ready,
   output logic [4:0]        slot_count
);
   import fsrm_pkg::*;

   logic [4:0] slot_count_ff, slot_count_in;
   logic [1:0] mode_ff, mode_in;

   // configuration registers, always writable
   assign csr_chan.ready = 1'b1;

   always_comb begin
      slot_count_in = slot_count_ff;
      mode_in       = mode_ff;
      if (csr_chan.valid) begin
         unique case (csr_chan.index)
            CSR_SLOT_COUNT:    slot_count_in = csr_chan.data;
            CSR_PIPELINE_MODE: mode_in = csr_chan.data[1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_count_ff <= SLOT_COUNT_RESET;
         mode_ff       <= MODE_EXT_CONV;
      end else begin
         slot_count_ff <= slot_count_in;
         mode_ff       <= mode_in;
      end
   end

   assign slot_count = slot_count_ff;

   // request word straight into the command queue
   assign cmd_valid      = req_chan.valid;
   assign req_chan.ready = cmd_ready;

   // classify the operation under the current pipeline mode
   always_comb begin
      cmd                  = '0;
      cmd.timestamp        = req_chan.timestamp;
      cmd.slot_index       = req_chan.slot_index;
      cmd.convert_failed   = req_chan.convert_failed;
      unique case (req_chan.op)
         OP_PACKET: begin
            cmd.kind = req_chan.first_packet ? CMD_CLAIM : CMD_MATCH;
            cmd.want = req_chan.first_packet ? SLOT_FREE : SLOT_CONVERTING;
         end
         OP_FRAME_DONE: begin
            cmd.kind = (mode_ff == MODE_PER_PACKET) ? CMD_DONE_MATCH : CMD_DONE_FREE;
            cmd.want = (mode_ff == MODE_PER_PACKET) ? SLOT_CONVERTING : SLOT_FREE;
            cmd.done_state = (mode_ff == MODE_PASS || mode_ff == MODE_PER_PACKET) ?
                             SLOT_CONVERTED : SLOT_READY;
            cmd.notify_app       = (mode_ff != MODE_EXT_CONV);
            cmd.notify_converter = (mode_ff == MODE_EXT_CONV);
         end
         OP_CONV_GET: begin
            cmd.kind = CMD_CONV_GET;
            cmd.want = SLOT_READY;
         end
         OP_CONV_PUT: begin
            cmd.kind = CMD_CONV_PUT;
            cmd.want = SLOT_CONVERTING;
         end
         OP_USER_GET: begin
            cmd.kind = CMD_USER_GET;
            cmd.want = (mode_ff == MODE_INT_CONV) ? SLOT_READY : SLOT_CONVERTED;
         end
         OP_USER_PUT: begin
            cmd.kind = CMD_USER_PUT;
            cmd.want = SLOT_IN_USER;
         end
         OP_STATS:  cmd.kind = CMD_STATS;
         default:   cmd.kind = CMD_NONE;
      endcase
   end

endmodule

>>> src/fsrm_queue.sv
`timescale 1ns / 1ps
// fsrm_queue: two-entry command queue between front and back
// depends on fsrm_pkg

module fsrm_queue (
   input  logic              clock,
   input  logic              reset,
   input  fsrm_pkg::cmd_type in_cmd,
   input  logic              in_valid,
   output logic              in_ready,
   output fsrm_pkg::cmd_type out_cmd,
   output logic              out_valid,
   input  logic              out_ready
);
   import fsrm_pkg::*;

   cmd_type    entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push, pop;

   assign in_ready  = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_cmd   = entry_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   // pointers and fill count
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= in_cmd;
      end
   end

endmodule

>>> src/fsrm_back.sv
`timescale 1ns / 1ps
// fsrm_back: executes commands on the slot ring and drives the response word
// depends on fsrm_pkg and fsrm_rsp_if

module fsrm_back #(
   parameter int MAX_SLOTS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  fsrm_pkg::cmd_type q_cmd,
   input  logic              q_valid,
   output logic              q_ready,
   input  logic [4:0]        slot_count,
   fsrm_rsp_if.source        rsp_chan
);
   import fsrm_pkg::*;

   localparam int SW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
   localparam int CW = $clog2(MAX_SLOTS + 1);

   // sequencer codes
   localparam logic [1:0] SEQ_IDLE   = 2'd0;
   localparam logic [1:0] SEQ_SEARCH = 2'd1;
   localparam logic [1:0] SEQ_TS1    = 2'd2;
   localparam logic [1:0] SEQ_TS2    = 2'd3;

   logic [1:0]    seq_ff, seq_in;
   cmd_type       cmd_ff, cmd_in;
   logic [2:0]    slot_ff [MAX_SLOTS];
   logic [2:0]    slot_in [MAX_SLOTS];
   logic [SW-1:0] prod_ff, prod_in;
   logic [SW-1:0] conv_ff, conv_in;
   logic [SW-1:0] cons_ff, cons_in;
   logic [SW-1:0] hit_ff, hit_in;
   logic [31:0]   busy_ff, busy_in;
   logic [31:0]   fail_ff, fail_in;
   rsp_type       rsp_ff, rsp_d;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_load;

   // timestamp memory
   logic [31:0]   ts_mem [MAX_SLOTS];
   logic [31:0]   ts_rd_ff;
   logic          ts_we;
   logic [SW-1:0] ts_waddr;
   logic [SW-1:0] ts_raddr;

   logic [CW-1:0] act_n;
   logic [SW-1:0] srch_start;
   logic [SW-1:0] start_ok;
   logic [MAX_SLOTS-1:0] match;
   logic [MAX_SLOTS-1:0] upper;
   logic          srch_hit;
   logic [SW-1:0] srch_slot;
   logic          done_en;
   logic [SW-1:0] done_slot;
   logic          sidx_ok;
   logic [SW-1:0] sidx;

   // slot after idx in the ring of act_n slots
   function automatic logic [SW-1:0] next_of(input logic [SW-1:0] idx,
                                             input logic [CW-1:0] n);
      logic [CW-1:0] x;
      x = CW'(idx) + CW'(1);
      return (x >= n) ? '0 : SW'(x);
   endfunction

   // slots in use, clamped to one up to the ring size
   always_comb begin
      if (slot_count == 5'd0) begin
         act_n = CW'(1);
      end else if (32'(slot_count) > MAX_SLOTS) begin
         act_n = CW'(MAX_SLOTS);
      end else begin
         act_n = CW'(slot_count);
      end
   end

   // rotated priority search for the wanted state
   always_comb begin
      start_ok  = (CW'(srch_start) < act_n) ? srch_start : '0;
      srch_slot = '0;
      for (int i = 0; i < MAX_SLOTS; i++) begin
         match[i] = (slot_ff[i] == cmd_ff.want) && (CW'(i) < act_n);
         upper[i] = match[i] && (SW'(i) >= start_ok);
      end
      srch_hit = |match;
      for (int i = MAX_SLOTS - 1; i >= 0; i--) begin
         if (match[i]) srch_slot = SW'(i);
      end
      for (int i = MAX_SLOTS - 1; i >= 0; i--) begin
         if (upper[i]) srch_slot = SW'(i);
      end
   end

   assign sidx_ok = (32'(cmd_ff.slot_index) < 32'(act_n));
   assign sidx    = SW'(cmd_ff.slot_index);
   assign q_ready = (seq_ff == SEQ_IDLE) && (!rsp_valid_ff || rsp_chan.ready);

   // sequencer
   always_comb begin
      seq_in   = seq_ff;
      cmd_in   = cmd_ff;
      slot_in  = slot_ff;
      prod_in  = prod_ff;
      conv_in  = conv_ff;
      cons_in  = cons_ff;
      hit_in   = hit_ff;
      busy_in  = busy_ff;
      fail_in  = fail_ff;
      rsp_d    = '0;
      rsp_load = 1'b0;
      ts_we    = 1'b0;
      ts_waddr = srch_slot;
      ts_raddr = srch_slot;
      done_en  = 1'b0;
      done_slot = srch_slot;

      // search start by pointer owner, retry starts after the mismatching slot
      unique case (cmd_ff.kind)
         CMD_CONV_GET: srch_start = conv_ff;
         CMD_USER_GET: srch_start = cons_ff;
         default:      srch_start = prod_ff;
      endcase
      if (seq_ff == SEQ_TS1) begin
         srch_start = next_of(hit_ff, act_n);
      end

      unique case (seq_ff)
         SEQ_IDLE: begin
            if (q_valid && q_ready) begin
               cmd_in = q_cmd;
               seq_in = SEQ_SEARCH;
            end
         end
         SEQ_SEARCH: begin
            seq_in   = SEQ_IDLE;
            rsp_load = 1'b1;
            unique case (cmd_ff.kind)
               CMD_CLAIM: begin
                  if (srch_hit) begin
                     slot_in[srch_slot] = SLOT_CONVERTING;
                     ts_we = 1'b1;
                     rsp_d.found_slot = 4'(srch_slot);
                  end else begin
                     busy_in = (busy_ff != '1) ? busy_ff + 32'd1 : busy_ff;
                     rsp_d.status = STAT_NO_SLOT;
                  end
               end
               CMD_MATCH, CMD_DONE_MATCH: begin
                  if (srch_hit) begin
                     hit_in   = srch_slot;
                     seq_in   = SEQ_TS1;
                     rsp_load = 1'b0;
                  end else begin
                     busy_in = (busy_ff != '1) ? busy_ff + 32'd1 : busy_ff;
                     rsp_d.status = STAT_NO_SLOT;
                  end
               end
               CMD_DONE_FREE: begin
                  if (srch_hit) begin
                     done_en = 1'b1;
                  end else begin
                     busy_in = (busy_ff != '1) ? busy_ff + 32'd1 : busy_ff;
                     rsp_d.status = STAT_NO_SLOT;
                  end
               end
               CMD_CONV_GET: begin
                  if (srch_hit) begin
                     slot_in[srch_slot] = SLOT_CONVERTING;
                     conv_in = next_of(srch_slot, act_n);
                     rsp_d.found_slot = 4'(srch_slot);
                  end else begin
                     rsp_d.status = STAT_NO_SLOT;
                  end
               end
               CMD_USER_GET: begin
                  if (srch_hit) begin
                     slot_in[srch_slot] = SLOT_IN_USER;
                     cons_in = next_of(srch_slot, act_n);
                     rsp_d.found_slot = 4'(srch_slot);
                  end else begin
                     rsp_d.status = STAT_NO_SLOT;
                  end
               end
               CMD_CONV_PUT: begin
                  if (sidx_ok && slot_ff[sidx] == cmd_ff.want) begin
                     rsp_d.found_slot = cmd_ff.slot_index;
                     if (cmd_ff.convert_failed) begin
                        slot_in[sidx] = SLOT_FREE;
                        fail_in = (fail_ff != '1) ? fail_ff + 32'd1 : fail_ff;
                     end else begin
                        slot_in[sidx] = SLOT_CONVERTED;
                        rsp_d.notify_app = 1'b1;
                     end
                  end else begin
                     rsp_d.status = STAT_BAD_SLOT;
                  end
               end
               CMD_USER_PUT: begin
                  if (sidx_ok && slot_ff[sidx] == cmd_ff.want) begin
                     slot_in[sidx] = SLOT_FREE;
                     rsp_d.found_slot = cmd_ff.slot_index;
                  end else begin
                     rsp_d.status = STAT_BAD_SLOT;
                  end
               end
               CMD_STATS: begin
                  rsp_d.busy_drops    = busy_ff;
                  rsp_d.convert_fails = fail_ff;
                  busy_in = '0;
                  fail_in = '0;
               end
               default: begin
               end
            endcase
         end
         SEQ_TS1: begin
            if (ts_rd_ff == cmd_ff.timestamp) begin
               rsp_load = 1'b1;
               seq_in   = SEQ_IDLE;
               rsp_d.found_slot = 4'(hit_ff);
               if (cmd_ff.kind == CMD_DONE_MATCH) begin
                  done_en   = 1'b1;
                  done_slot = hit_ff;
               end
            end else if (srch_hit) begin
               hit_in = srch_slot;
               seq_in = SEQ_TS2;
            end else begin
               rsp_load = 1'b1;
               seq_in   = SEQ_IDLE;
               busy_in  = (busy_ff != '1) ? busy_ff + 32'd1 : busy_ff;
               rsp_d.status = STAT_NO_SLOT;
            end
         end
         SEQ_TS2: begin
            rsp_load = 1'b1;
            seq_in   = SEQ_IDLE;
            if (ts_rd_ff == cmd_ff.timestamp) begin
               rsp_d.found_slot = 4'(hit_ff);
               if (cmd_ff.kind == CMD_DONE_MATCH) begin
                  done_en   = 1'b1;
                  done_slot = hit_ff;
               end
            end else begin
               rsp_d.status = STAT_MISMATCH;
            end
         end
      endcase

      // frame completion commit
      if (done_en) begin
         slot_in[done_slot] = cmd_ff.done_state;
         ts_we    = 1'b1;
         ts_waddr = done_slot;
         prod_in  = next_of(done_slot, act_n);
         rsp_d.found_slot       = 4'(done_slot);
         rsp_d.notify_app       = cmd_ff.notify_app;
         rsp_d.notify_converter = cmd_ff.notify_converter;
      end
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff       <= SEQ_IDLE;
         slot_ff      <= '{default: SLOT_FREE};
         prod_ff      <= '0;
         conv_ff      <= '0;
         cons_ff      <= '0;
         busy_ff      <= '0;
         fail_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         seq_ff       <= seq_in;
         slot_ff      <= slot_in;
         prod_ff      <= prod_in;
         conv_ff      <= conv_in;
         cons_ff      <= cons_in;
         busy_ff      <= busy_in;
         fail_ff      <= fail_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      hit_ff <= hit_in;
      if (rsp_load) begin
         rsp_ff <= rsp_d;
      end
   end

   // timestamp memory, one write and one registered read port
   always_ff @(posedge clock) begin
      if (ts_we) begin
         ts_mem[ts_waddr] <= cmd_ff.timestamp;
      end
      ts_rd_ff <= ts_mem[ts_raddr];
   end

   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.status           = rsp_ff.status;
   assign rsp_chan.found_slot       = rsp_ff.found_slot;
   assign rsp_chan.notify_app       = rsp_ff.notify_app;
   assign rsp_chan.notify_converter = rsp_ff.notify_converter;
   assign rsp_chan.busy_drops       = rsp_ff.busy_drops;
   assign rsp_chan.convert_fails    = rsp_ff.convert_fails;

endmodule

>>> src/frame_slot_ring_manager_core.sv
`timescale 1ns / 1ps
// Frame slot ring manager. Each request word (packet, frame done, converter
// get/put, user get/put, stats read) yields exactly one response word. The
// front takes words into a two-entry command queue while the back works, so
// up to two requests can wait behind the one in progress. A finished
// response waits in an output register; until it is taken the back starts no
// new command. The back handles one command at a time: a search state, then
// for a packet or per-packet frame done that hits, a timestamp compare, and on
// a mismatch a retry search with a second compare; each compare uses the
// registered read of the timestamp memory. Slot searches are a combinational
// rotated priority pick over the active slots from the owning pointer.
// Configuration words must only be written while no request is outstanding.
// depends on fsrm_pkg, the channel interfaces, fsrm_front, fsrm_queue, fsrm_back

module frame_slot_ring_manager_core #(
   parameter int MAX_SLOTS = 16
) (
   input  logic       clock,
   input  logic       reset,
   fsrm_req_if.sink   req_chan,
   fsrm_rsp_if.source rsp_chan,
   fsrm_csr_if.sink   csr_chan
);
   import fsrm_pkg::*;

   cmd_type    front_cmd;
   logic       front_valid;
   logic       front_ready;
   cmd_type    q_cmd;
   logic       q_valid;
   logic       q_ready;
   logic [4:0] slot_count;

   // accept and classify
   fsrm_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .csr_chan   (csr_chan),
      .cmd        (front_cmd),
      .cmd_valid  (front_valid),
      .cmd_ready  (front_ready),
      .slot_count (slot_count)
   );

   // decoupling queue
   fsrm_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_cmd    (front_cmd),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .out_cmd   (q_cmd),
      .out_valid (q_valid),
      .out_ready (q_ready)
   );

   // execute on the ring
   fsrm_back #(
      .MAX_SLOTS (MAX_SLOTS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_cmd      (q_cmd),
      .q_valid    (q_valid),
      .q_ready    (q_ready),
      .slot_count (slot_count),
      .rsp_chan   (rsp_chan)
   );

endmodule

>>> test/frame_slot_ring_manager_core_tb.sv
`timescale 1ns / 1ps
// frame_slot_ring_manager_core_tb: self-checking bench for the frame slot ring manager
// drives request and csr words, predicts every response word and checks it in order
// depends on fsrm_pkg, the fsrm channel interfaces and frame_slot_ring_manager_core

module frame_slot_ring_manager_core_tb;
   import fsrm_pkg::*;

   localparam int RING_SLOTS = 16;
   localparam int NONE_FOUND = -1;
   localparam int CYCLE_LIMIT = 400000;
   localparam int SETTLE_CYCLES = 12;
   localparam int RSP_HOLD_CYCLES = 150;
   localparam logic [2:0] OP_UNDEFINED = 3'd7;

   typedef struct packed {
      logic [2:0]  op;
      logic [31:0] stamp;
      logic        first;
      logic [3:0]  slot;
      logic        failed;
   } ring_request_type;

   logic clock;
   logic reset;

   fsrm_req_if req_bus ();
   fsrm_rsp_if rsp_bus ();
   fsrm_csr_if csr_bus ();

   frame_slot_ring_manager_core #(.MAX_SLOTS(RING_SLOTS)) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   // predicted ring state and configuration
   logic [4:0]  cfg_slot_count = SLOT_COUNT_RESET;
   logic [1:0]  cfg_mode = MODE_EXT_CONV;
   logic [2:0]  slot_phase [RING_SLOTS];
   logic [31:0] slot_stamp [RING_SLOTS];
   int          producer_at = 0;
   int          converter_at = 0;
   int          consumer_at = 0;
   logic [31:0] busy_drop_count = '0;
   logic [31:0] convert_fail_count = '0;

   rsp_type awaited_rsp [$];
   int      error_count = 0;
   int      rsp_seen = 0;
   int      cycle_count = 0;
   int      rsp_hold_left = 0;
   bit      tx_steady = 1'b0;
   bit      rx_steady = 1'b0;

   // clock and cycle limit
   initial clock = 1'b0;
   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d words still awaited",
                  cycle_count, awaited_rsp.size());
         $display("frame_slot_ring_manager_core_tb: done, errors");
         $finish;
      end
   end

   task automatic report_error(input string msg);
      $display("ERROR @%0t: %s", $realtime, msg);
      error_count++;
   endtask

   // ring search helpers
   function automatic int ring_size();
      if (cfg_slot_count == 0) return 1;
      if (cfg_slot_count > RING_SLOTS) return RING_SLOTS;
      return int'(cfg_slot_count);
   endfunction

   function automatic int ring_next(input int idx);
      return (idx + 1 >= ring_size()) ? 0 : idx + 1;
   endfunction

   function automatic int ring_search(input int start, input logic [2:0] want);
      int n;
      int idx;
      int k;
      n = ring_size();
      idx = (start < n) ? start : 0;
      for (k = 0; k < n; k++) begin
         if (slot_phase[idx] == want) return idx;
         idx = ring_next(idx);
      end
      return NONE_FOUND;
   endfunction

   function automatic logic [31:0] sat_inc(input logic [31:0] c);
      return (c == '1) ? c : c + 32'd1;
   endfunction

   // converting slot with a matching stamp, one retry after the first mismatch
   function automatic int match_stamp(input logic [31:0] stamp, output bit mism);
      int s;
      mism = 1'b0;
      s = ring_search(producer_at, SLOT_CONVERTING);
      if (s != NONE_FOUND && slot_stamp[s] != stamp) begin
         s = ring_search(ring_next(s), SLOT_CONVERTING);
         if (s != NONE_FOUND && slot_stamp[s] != stamp) mism = 1'b1;
      end
      return s;
   endfunction

   // next response word of the ring, updates the predicted state
   function automatic rsp_type ring_outcome(input ring_request_type r);
      rsp_type o;
      int s;
      bit mism;
      o = '0;
      mism = 1'b0;
      case (r.op)
         OP_PACKET: begin
            if (r.first) begin
               s = ring_search(producer_at, SLOT_FREE);
               if (s != NONE_FOUND) begin
                  slot_phase[s] = SLOT_CONVERTING;
                  slot_stamp[s] = r.stamp;
               end
            end else begin
               s = match_stamp(r.stamp, mism);
            end
            if (s == NONE_FOUND) begin
               busy_drop_count = sat_inc(busy_drop_count);
               o.status = STAT_NO_SLOT;
            end else if (mism) begin
               o.status = STAT_MISMATCH;
            end else begin
               o.found_slot = 4'(s);
            end
         end
         OP_FRAME_DONE: begin
            if (cfg_mode == MODE_PER_PACKET) s = match_stamp(r.stamp, mism);
            else s = ring_search(producer_at, SLOT_FREE);
            if (s == NONE_FOUND) begin
               busy_drop_count = sat_inc(busy_drop_count);
               o.status = STAT_NO_SLOT;
            end else if (mism) begin
               o.status = STAT_MISMATCH;
            end else begin
               slot_stamp[s] = r.stamp;
               producer_at = ring_next(s);
               o.found_slot = 4'(s);
               if (cfg_mode == MODE_PASS || cfg_mode == MODE_PER_PACKET) begin
                  slot_phase[s] = SLOT_CONVERTED;
                  o.notify_app = 1'b1;
               end else begin
                  slot_phase[s] = SLOT_READY;
                  if (cfg_mode == MODE_EXT_CONV) o.notify_converter = 1'b1;
                  else o.notify_app = 1'b1;
               end
            end
         end
         OP_CONV_GET: begin
            s = ring_search(converter_at, SLOT_READY);
            if (s == NONE_FOUND) begin
               o.status = STAT_NO_SLOT;
            end else begin
               slot_phase[s] = SLOT_CONVERTING;
               converter_at = ring_next(s);
               o.found_slot = 4'(s);
            end
         end
         OP_CONV_PUT: begin
            if (int'(r.slot) >= ring_size() || slot_phase[r.slot] != SLOT_CONVERTING) begin
               o.status = STAT_BAD_SLOT;
            end else begin
               o.found_slot = r.slot;
               if (r.failed) begin
                  slot_phase[r.slot] = SLOT_FREE;
                  convert_fail_count = sat_inc(convert_fail_count);
               end else begin
                  slot_phase[r.slot] = SLOT_CONVERTED;
                  o.notify_app = 1'b1;
               end
            end
         end
         OP_USER_GET: begin
            s = ring_search(consumer_at,
                            (cfg_mode == MODE_INT_CONV) ? SLOT_READY : SLOT_CONVERTED);
            if (s == NONE_FOUND) begin
               o.status = STAT_NO_SLOT;
            end else begin
               slot_phase[s] = SLOT_IN_USER;
               consumer_at = ring_next(s);
               o.found_slot = 4'(s);
            end
         end
         OP_USER_PUT: begin
            if (int'(r.slot) >= ring_size() || slot_phase[r.slot] != SLOT_IN_USER) begin
               o.status = STAT_BAD_SLOT;
            end else begin
               slot_phase[r.slot] = SLOT_FREE;
               o.found_slot = r.slot;
            end
         end
         OP_STATS: begin
            o.busy_drops = busy_drop_count;
            o.convert_fails = convert_fail_count;
            busy_drop_count = '0;
            convert_fail_count = '0;
         end
         default: ;
      endcase
      return o;
   endfunction

   // idle lengths: mostly none or short, now and then long
   function automatic int idle_len();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic ring_request_type make_word(input logic [2:0] op,
                                                  input logic [31:0] stamp,
                                                  input logic first, input logic [3:0] slot,
                                                  input logic failed);
      ring_request_type r;
      r.op = op;
      r.stamp = stamp;
      r.first = first;
      r.slot = slot;
      r.failed = failed;
      return r;
   endfunction

   // random slot of the active ring in the given state
   function automatic int pick_slot_in(input logic [2:0] want);
      int hits [$];
      int k;
      for (k = 0; k < ring_size(); k++)
         if (slot_phase[k] == want) hits.push_back(k);
      if (hits.size() == 0) return NONE_FOUND;
      return hits[$urandom_range(0, hits.size() - 1)];
   endfunction

   // stamp of a frame in flight most of the time, else the fallback
   function automatic logic [31:0] frame_stamp(input logic [31:0] fallback);
      int s;
      s = pick_slot_in(SLOT_CONVERTING);
      if (s != NONE_FOUND && $urandom_range(0, 99) < 80) return slot_stamp[s];
      return fallback;
   endfunction

   // random word shaped after the predicted ring so frames go through all states
   function automatic ring_request_type random_word();
      ring_request_type r;
      int pick;
      int roll;
      int s;
      r = make_word(OP_PACKET, $urandom, 1'($urandom_range(0, 1)),
                    4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
      roll = $urandom_range(0, 99);
      if (roll < 4) r.stamp = '0;
      else if (roll < 8) r.stamp = '1;
      pick = $urandom_range(0, 99);
      if (pick < 18) begin
         r.op = OP_PACKET;
         r.first = 1'b1;
      end else if (pick < 36) begin
         r.op = OP_PACKET;
         r.first = 1'b0;
         r.stamp = frame_stamp(r.stamp);
      end else if (pick < 50) begin
         r.op = OP_FRAME_DONE;
         if (cfg_mode == MODE_PER_PACKET) r.stamp = frame_stamp(r.stamp);
      end else if (pick < 60) begin
         r.op = OP_CONV_GET;
      end else if (pick < 72) begin
         r.op = OP_CONV_PUT;
         s = pick_slot_in(SLOT_CONVERTING);
         if (s != NONE_FOUND && $urandom_range(0, 99) < 80) r.slot = 4'(s);
         r.failed = ($urandom_range(0, 3) == 0);
      end else if (pick < 82) begin
         r.op = OP_USER_GET;
      end else if (pick < 94) begin
         r.op = OP_USER_PUT;
         s = pick_slot_in(SLOT_IN_USER);
         if (s != NONE_FOUND && $urandom_range(0, 99) < 80) r.slot = 4'(s);
      end else if (pick < 97) begin
         r.op = OP_STATS;
      end else begin
         r.op = OP_UNDEFINED;
      end
      return r;
   endfunction

   // send one request word, predict its response on acceptance
   task automatic send_word(input ring_request_type r);
      int gap;
      gap = tx_steady ? 0 : idle_len();
      @(negedge clock);
      if (gap > 0) begin
         req_bus.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.op = r.op;
      req_bus.timestamp = r.stamp;
      req_bus.first_packet = r.first;
      req_bus.slot_index = r.slot;
      req_bus.convert_failed = r.failed;
      req_bus.valid = 1'b1;
      @(posedge clock);
      while (req_bus.ready !== 1'b1) @(posedge clock);
      awaited_rsp.push_back(ring_outcome(r));
   endtask

   // stop offering and wait until every response word is back
   task automatic wait_idle();
      @(negedge clock);
      req_bus.valid = 1'b0;
      while (awaited_rsp.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic idx, input logic [4:0] value);
      wait_idle();
      @(negedge clock);
      csr_bus.index = idx;
      csr_bus.data = value;
      csr_bus.valid = 1'b1;
      @(posedge clock);
      while (csr_bus.ready !== 1'b1) @(posedge clock);
      if (idx == CSR_SLOT_COUNT) cfg_slot_count = value;
      else cfg_mode = value[1:0];
      @(negedge clock);
      csr_bus.valid = 1'b0;
   endtask

   // response checker
   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want)
         report_error($sformatf("word %0d %s: got %0h, want %0h", rsp_seen, name, got, want));
   endtask

   always @(posedge clock) begin : rsp_check
      rsp_type want;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (awaited_rsp.size() == 0) begin
            report_error("response word with nothing awaited");
         end else begin
            want = awaited_rsp.pop_front();
            check_field("status", 32'(rsp_bus.status), 32'(want.status));
            check_field("found_slot", 32'(rsp_bus.found_slot), 32'(want.found_slot));
            check_field("notify_app", 32'(rsp_bus.notify_app), 32'(want.notify_app));
            check_field("notify_converter", 32'(rsp_bus.notify_converter),
                        32'(want.notify_converter));
            check_field("busy_drops", rsp_bus.busy_drops, want.busy_drops);
            check_field("convert_fails", rsp_bus.convert_fails, want.convert_fails);
         end
         rsp_seen++;
      end
   end

   // response side ready: random stalls, plus a long hold when asked
   initial begin : rsp_drain
      int stall_left;
      stall_left = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_left > 0) begin
            rsp_bus.ready = 1'b0;
            rsp_hold_left--;
         end else if (stall_left > 0) begin
            rsp_bus.ready = 1'b0;
            stall_left--;
         end else begin
            stall_left = rx_steady ? 0 : idle_len();
            if (stall_left > 0) begin
               rsp_bus.ready = 1'b0;
               stall_left--;
            end else begin
               rsp_bus.ready = 1'b1;
            end
         end
      end
   end

   // error paths on an empty ring, then frames through every slot state
   task automatic test_empty_ring_and_lifecycle();
      send_word(make_word(OP_USER_GET, 32'h0, 1'b0, 4'h0, 1'b0));
      send_word(make_word(OP_CONV_GET, 32'h0, 1'b0, 4'h0, 1'b0));
      send_word(make_word(OP_CONV_PUT, 32'h0, 1'b0, 4'h0, 1'b0));
      send_word(make_word(OP_USER_PUT, 32'h0, 1'b0, 4'hF, 1'b0));
      send_word(make_word(OP_PACKET, 32'h5, 1'b0, 4'h0, 1'b0));
      send_word(make_word(OP_UNDEFINED, 32'hFFFF_FFFF, 1'b1, 4'hF, 1'b1));
      // two frames in flight, then stamp matching with and without retry
      send_word(make_word(OP_PACKET, 32'hFFFF_FFFF, 1'b1, 4'h0, 1'b0));
      send_word(make_word(OP_PACKET, 32'h0, 1'b1, 4'h0, 1'b0));
      send_word(make_word(OP_PACKET, 32'h0, 1'b0, 4'h0, 1'b0));
      send_word(make_word(OP_PACKET, 32'h1234_5678, 1'b0, 4'h0, 1'b0));
      send_word(make_word(OP_PACKET, 32'hFFFF_FFFF, 1'b0, 4'h0, 1'b0));
      send_word(make_word(OP_FRAME_DONE, 32'hA5A5_A5A5, 1'b0, 4'h0, 1'b0));
      send_word(make_word(OP_CONV_GET, 32'h0, 1'b0, 4'h0, 1'b0));
      send_word(make_word(OP_CONV_PUT, 32'h0, 1'b0, 4'h0, 1'b1));
      send_word(make_word(OP_CONV_PUT, 32'h0, 1'b0, 4'h1, 1'b0));
      send_word(make_word(OP_USER_GET, 32'h0, 1'b0, 4'h0, 1'b0));
      send_word(make_word(OP_USER_PUT, 32'h0, 1'b0, 4'h1, 1'b0));
      send_word(make_word(OP_STATS, 32'h0, 1'b0, 4'h0, 1'b0));
      send_word(make_word(OP_STATS, 32'h0, 1'b0, 4'h0, 1'b0));
   endtask

   // two-slot ring with pointers left beyond the count, per-packet mode
   task automatic test_small_ring_wrap();
      write_csr(CSR_SLOT_COUNT, 5'd2);
      write_csr(CSR_PIPELINE_MODE, {3'b000, MODE_PER_PACKET});
      send_word(make_word(OP_PACKET, 32'h7, 1'b1, 4'h0, 1'b0));
      send_word(make_word(OP_FRAME_DONE, 32'h7, 1'b0, 4'h0, 1'b0));
      send_word(make_word(OP_FRAME_DONE, 32'h9, 1'b0, 4'h0, 1'b0));
      send_word(make_word(OP_CONV_PUT, 32'h0, 1'b0, 4'h2, 1'b0));
      send_word(make_word(OP_USER_GET, 32'h0, 1'b0, 4'h0, 1'b0));
      send_word(make_word(OP_USER_PUT, 32'h0, 1'b0, 4'h0, 1'b0));
      send_word(make_word(OP_STATS, 32'h0, 1'b0, 4'h0, 1'b0));
   endtask

   // one configuration, then random frame traffic
   task automatic test_random_phase(input logic [4:0] count, input logic [1:0] mode,
                                    input int n_items, input bit steady);
      write_csr(CSR_SLOT_COUNT, count);
      write_csr(CSR_PIPELINE_MODE, {3'($urandom_range(0, 7)), mode});
      tx_steady = steady;
      rx_steady = steady;
      repeat (n_items) send_word(random_word());
      tx_steady = 1'b0;
      rx_steady = 1'b0;
   endtask

   // long response hold while requests keep coming, then a full drain
   task automatic test_response_backpressure();
      write_csr(CSR_SLOT_COUNT, 5'd8);
      write_csr(CSR_PIPELINE_MODE, {3'b000, MODE_PASS});
      @(posedge clock);
      rsp_hold_left = RSP_HOLD_CYCLES;
      tx_steady = 1'b1;
      repeat (16) send_word(random_word());
      tx_steady = 1'b0;
      wait_idle();
      repeat (8) send_word(random_word());
   endtask

   initial begin
      int k;
      for (k = 0; k < RING_SLOTS; k++) begin
         slot_phase[k] = SLOT_FREE;
         slot_stamp[k] = '0;
      end
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.op = OP_PACKET;
      req_bus.timestamp = '0;
      req_bus.first_packet = 1'b0;
      req_bus.slot_index = '0;
      req_bus.convert_failed = 1'b0;
      csr_bus.valid = 1'b0;
      csr_bus.index = CSR_SLOT_COUNT;
      csr_bus.data = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_empty_ring_and_lifecycle();
      test_small_ring_wrap();
      test_random_phase(5'd16, MODE_EXT_CONV, 40, 1'b0);
      test_random_phase(5'd1, MODE_INT_CONV, 40, 1'b0);
      test_random_phase(5'd0, MODE_PASS, 40, 1'b0);
      test_random_phase(5'd31, MODE_PER_PACKET, 90, 1'b0);
      test_random_phase(5'd3, MODE_PER_PACKET, 60, 1'b0);
      test_random_phase(5'd17, MODE_INT_CONV, 60, 1'b0);
      test_random_phase(5'd2, MODE_EXT_CONV, 50, 1'b0);
      test_random_phase(5'($urandom_range(1, 16)), 2'($urandom_range(0, 3)), 60, 1'b1);
      test_response_backpressure();
      test_random_phase(5'($urandom_range(4, 16)), 2'($urandom_range(0, 3)), 60, 1'b0);

      wait_idle();
      if (error_count == 0) begin
         $display("frame_slot_ring_manager_core_tb: done, clean");
      end else begin
         $display("frame_slot_ring_manager_core_tb: done, errors");
      end
      $finish;
   end

endmodule

>>> filelist.f
src/fsrm_pkg.sv
src/fsrm_req_if.sv
src/fsrm_rsp_if.sv
src/fsrm_csr_if.sv
src/fsrm_front.sv
src/fsrm_queue.sv
src/fsrm_back.sv
src/frame_slot_ring_manager_core.sv
test/frame_slot_ring_manager_core_tb.sv
